// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by lookat_view_matrix.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/lvm_pkg.sv =====
// ----------------------------------------------------------------------------
// lvm_pkg
// Types and constants of the look-at view matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package lvm_pkg;

    localparam int unsigned LVM_WORD_BITS = 32;
    localparam int unsigned LVM_FRAC_BITS = 16;

    // normalization: largest magnitude scaled to [2^30, 2^31)
    localparam int unsigned NORM_BITS  = 31;
    localparam int unsigned SUM_BITS   = 64;
    localparam int unsigned ROOT_STEPS = SUM_BITS / 2;

    localparam logic [1:0] COL_LAST = 2'd3;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_lvm_in;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] entry_0;
        logic signed [31:0] entry_1;
        logic signed [31:0] entry_2;
        logic signed [31:0] entry_3;
        logic               degenerate;
        logic               last_column;
    } t_lvm_out;

endpackage

`default_nettype wire

// ===== rtl/lvm_norm.sv =====
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined 3-vector normalizer: magnitude scaling, sum of squares,
// one square-root bit per stage, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lvm_norm
    import lvm_pkg::*;
#(
    parameter int unsigned VEC_BITS  = 33,
    parameter int unsigned FRAC_BITS = LVM_FRAC_BITS,
    parameter int unsigned TAG_BITS  = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0][VEC_BITS-1:0]   i_vec,
    input  logic [TAG_BITS-1:0]        i_tag,
    output logic                       o_valid,
    output logic                       o_nonzero,
    output logic [2:0][FRAC_BITS+1:0]  o_unit,
    output logic [TAG_BITS-1:0]        o_tag
);

    localparam int unsigned POS_BITS  = $clog2(VEC_BITS);
    localparam int unsigned TOP_POS   = NORM_BITS - 1;
    localparam int unsigned QUO_BITS  = FRAC_BITS + 1;
    localparam int unsigned DVD_BITS  = NORM_BITS + FRAC_BITS + 1;
    localparam int unsigned ROOT_BITS = SUM_BITS / 2;
    localparam int unsigned UNIT_BITS = FRAC_BITS + 2;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] m;
        logic [2:0]                neg;
        logic                      nz;
        logic [TAG_BITS-1:0]       tag;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       nz;
        logic [TAG_BITS-1:0] tag;
    } t_dside;

    // stage A: magnitudes
    logic                      r_a_v;
    logic [2:0][VEC_BITS-1:0]  r_a_mag;
    logic [2:0]                r_a_neg;
    logic [TAG_BITS-1:0]       r_a_tag;
    // stage B: largest magnitude
    logic                      r_b_v;
    logic [2:0][VEC_BITS-1:0]  r_b_mag;
    logic [2:0]                r_b_neg;
    logic [TAG_BITS-1:0]       r_b_tag;
    logic [VEC_BITS-1:0]       r_b_big;
    // stage C: leading one
    logic                      r_c_v;
    logic [2:0][VEC_BITS-1:0]  r_c_mag;
    logic [2:0]                r_c_neg;
    logic [TAG_BITS-1:0]       r_c_tag;
    logic [POS_BITS-1:0]       r_c_pos;
    logic                      r_c_nz;
    // stage D: scaled, E: squares
    logic                      r_d_v;
    t_side                     r_d_side;
    logic                      r_e_v;
    t_side                     r_e_side;
    logic [2:0][2*NORM_BITS-1:0] r_e_sq;
    // square root
    logic                      r_rt_v    [ROOT_STEPS+1];
    logic [SUM_BITS-1:0]       r_rt_n    [ROOT_STEPS+1];
    logic [SUM_BITS-1:0]       r_rt_res  [ROOT_STEPS+1];
    t_side                     r_rt_side [ROOT_STEPS+1];
    // division
    logic                      r_dv_v    [QUO_BITS+1];
    logic [2:0][DVD_BITS-1:0]  r_dv_rem  [QUO_BITS+1];
    logic [2:0][QUO_BITS-1:0]  r_dv_q    [QUO_BITS+1];
    logic [ROOT_BITS-1:0]      r_dv_len  [QUO_BITS+1];
    t_dside                    r_dv_side [QUO_BITS+1];

    logic [2:0][VEC_BITS-1:0]  n_a_mag;
    logic [VEC_BITS-1:0]       n_b_big;
    logic [POS_BITS-1:0]       n_c_pos;
    t_side                     n_d_side;
    logic [2:0][2*NORM_BITS-1:0] n_e_sq;
    logic [SUM_BITS-1:0]       n_sum;
    logic [ROOT_BITS-1:0]      n_len;
    logic [2:0][DVD_BITS-1:0]  n_dv_rem;
    t_dside                    n_dv_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a_mag[k] = i_vec[k][VEC_BITS-1] ? VEC_BITS'(0) - i_vec[k] : i_vec[k];
        end
    end

    always_comb begin
        n_b_big = r_a_mag[0];
        if (r_a_mag[1] > n_b_big) n_b_big = r_a_mag[1];
        if (r_a_mag[2] > n_b_big) n_b_big = r_a_mag[2];
    end

    always_comb begin
        n_c_pos = '0;
        for (int i = 0; i < VEC_BITS; i++) begin
            if (r_b_big[i]) n_c_pos = POS_BITS'(i);
        end
    end

    always_comb begin
        n_d_side.neg = r_c_neg;
        n_d_side.nz  = r_c_nz;
        n_d_side.tag = r_c_tag;
        for (int k = 0; k < 3; k++) begin
            if (r_c_pos > POS_BITS'(TOP_POS)) begin
                n_d_side.m[k] = NORM_BITS'(r_c_mag[k] >> (r_c_pos - POS_BITS'(TOP_POS)));
            end else begin
                n_d_side.m[k] = NORM_BITS'(r_c_mag[k]) << (POS_BITS'(TOP_POS) - r_c_pos);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e_sq[k] = r_d_side.m[k] * r_d_side.m[k];
        end
        n_sum = SUM_BITS'(r_e_sq[0]) + SUM_BITS'(r_e_sq[1]) + SUM_BITS'(r_e_sq[2]);
    end

    always_comb begin
        n_len = ROOT_BITS'(r_rt_res[ROOT_STEPS]);
        for (int k = 0; k < 3; k++) begin
            n_dv_rem[k] = (DVD_BITS'(r_rt_side[ROOT_STEPS].m[k]) << FRAC_BITS)
                        + DVD_BITS'(n_len >> 1);
        end
        n_dv_side.neg = r_rt_side[ROOT_STEPS].neg;
        n_dv_side.nz  = r_rt_side[ROOT_STEPS].nz;
        n_dv_side.tag = r_rt_side[ROOT_STEPS].tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_c_v     <= 1'b0;
            r_d_v     <= 1'b0;
            r_e_v     <= 1'b0;
            r_rt_v[0] <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_a_v     <= i_valid;
            r_b_v     <= r_a_v;
            r_c_v     <= r_b_v;
            r_d_v     <= r_c_v;
            r_e_v     <= r_d_v;
            r_rt_v[0] <= r_e_v;
            r_dv_v[0] <= r_rt_v[ROOT_STEPS];
        end
        if (i_en) begin
            r_a_mag <= n_a_mag;
            for (int k = 0; k < 3; k++) r_a_neg[k] <= i_vec[k][VEC_BITS-1];
            r_a_tag <= i_tag;
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            r_b_tag <= r_a_tag;
            r_b_big <= n_b_big;
            r_c_mag <= r_b_mag;
            r_c_neg <= r_b_neg;
            r_c_tag <= r_b_tag;
            r_c_pos <= n_c_pos;
            r_c_nz  <= |r_b_big;
            r_d_side <= n_d_side;
            r_e_side <= r_d_side;
            r_e_sq   <= n_e_sq;
            r_rt_n[0]    <= n_sum;
            r_rt_res[0]  <= '0;
            r_rt_side[0] <= r_e_side;
            r_dv_rem[0]  <= n_dv_rem;
            r_dv_q[0]    <= '0;
            r_dv_len[0]  <= n_len;
            r_dv_side[0] <= n_dv_side;
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
        logic [SUM_BITS-1:0] n_try;
        logic [SUM_BITS-1:0] n_n;
        logic [SUM_BITS-1:0] n_res;

        always_comb begin
            n_try = r_rt_res[k] + BIT;
            if (r_rt_n[k] >= n_try) begin
                n_n   = r_rt_n[k] - n_try;
                n_res = (r_rt_res[k] >> 1) + BIT;
            end else begin
                n_n   = r_rt_n[k];
                n_res = r_rt_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_rt_v[k+1] <= r_rt_v[k];
            end
            if (i_en) begin
                r_rt_n[k+1]    <= n_n;
                r_rt_res[k+1]  <= n_res;
                r_rt_side[k+1] <= r_rt_side[k];
            end
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
        localparam int unsigned SH = QUO_BITS - 1 - j;
        logic [DVD_BITS-1:0]      n_dsr;
        logic [2:0][DVD_BITS-1:0] n_rem;
        logic [2:0][QUO_BITS-1:0] n_q;

        always_comb begin
            n_dsr = DVD_BITS'(r_dv_len[j]) << SH;
            for (int k = 0; k < 3; k++) begin
                n_rem[k] = r_dv_rem[j][k];
                n_q[k]   = r_dv_q[j][k];
                if (r_dv_rem[j][k] >= n_dsr) begin
                    n_rem[k]     = r_dv_rem[j][k] - n_dsr;
                    n_q[k][SH]   = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
            if (i_en) begin
                r_dv_rem[j+1]  <= n_rem;
                r_dv_q[j+1]    <= n_q;
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dv_side[QUO_BITS].neg[k]) begin
                o_unit[k] = UNIT_BITS'(0) - UNIT_BITS'(r_dv_q[QUO_BITS][k]);
            end else begin
                o_unit[k] = UNIT_BITS'(r_dv_q[QUO_BITS][k]);
            end
        end
    end

    assign o_valid   = r_dv_v[QUO_BITS];
    assign o_nonzero = r_dv_side[QUO_BITS].nz;
    assign o_tag     = r_dv_side[QUO_BITS].tag;

endmodule

`default_nettype wire

// ===== rtl/lookat_view_matrix.sv =====
// ----------------------------------------------------------------------------
// lookat_view_matrix
// Look-at view matrix in signed fixed point, emitted one column per transfer.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-----------------------
//   input    | i_in_valid   | o_in_stall   | i_in_data  (t_lvm_in)
//   output   | o_out_valid  | i_out_stall  | o_out_data (t_lvm_out)
//
// The four column transfers per item on the single output port bound the sustained
// rate; the pipeline takes one item per cycle until full.
// Both normalizers take FRAC_BITS + 40 stages (32 root stages, FRAC_BITS + 1
// divide stages). Reset clears only valid bits and the column counter.
// An output stall holds the column on display and stalls the whole pipeline
// once its final stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lookat_view_matrix
    import lvm_pkg::*;
#(
    parameter int unsigned WORD_BITS = LVM_WORD_BITS,
    parameter int unsigned FRAC_BITS = LVM_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_lvm_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_lvm_out o_out_data
);

    localparam int unsigned SAT_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int unsigned UW       = FRAC_BITS + 2;
    localparam int unsigned DIF_BITS = 33;
    localparam int unsigned PRD_BITS = UW + 32;
    localparam int unsigned RR_BITS  = PRD_BITS + 1;
    localparam int unsigned UPR_BITS = 2 * UW;
    localparam int unsigned UR_BITS  = UPR_BITS + 1;
    localparam int unsigned DOT_BITS = PRD_BITS + 2;
    localparam int unsigned WIDE     = 2 * FRAC_BITS + 40;
    localparam logic signed [WIDE-1:0] ONE = WIDE'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
    } t_tag1;

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][UW-1:0] f;
        logic             nz;
    } t_tag2;

    localparam int unsigned TAG_BITS1 = $bits(t_tag1);
    localparam int unsigned TAG_BITS2 = $bits(t_tag2);

    function automatic logic signed [WIDE-1:0] rnd(input logic signed [WIDE-1:0] x);
        logic [WIDE-1:0] m;
        m = x[WIDE-1] ? WIDE'(0) - x : x;
        m = (m + (WIDE'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[WIDE-1] ? $signed(WIDE'(0) - m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat(input logic signed [WIDE-1:0] x);
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        logic signed [WIDE-1:0] v;
        hi = $signed((WIDE'(1) << (SAT_BITS - 1)) - WIDE'(1));
        lo = ~hi;
        v  = x;
        if (x > hi) v = hi;
        if (x < lo) v = lo;
        return v[31:0];
    endfunction

    logic en;
    logic ser_free;

    // input register
    logic    r_s0_v;
    t_lvm_in r_s0_d;

    logic [2:0][DIF_BITS-1:0] w_fd;
    t_tag1                    w_tag1;
    logic                     w_n1_v;
    logic                     w_n1_nz;
    logic [2:0][UW-1:0]       w_n1_f;
    logic [TAG_BITS1-1:0]     w_n1_tag;
    t_tag1                    w_t1;

    // cross f x up
    logic                     r_x1_v;
    logic [5:0][PRD_BITS-1:0] r_x1_p;
    logic [2:0][31:0]         r_x1_eye;
    logic [2:0][UW-1:0]       r_x1_f;
    logic                     r_x1_nz;
    logic                     r_x2_v;
    logic [2:0][RR_BITS-1:0]  r_x2_rr;
    t_tag2                    r_x2_tag;

    logic                     w_n2_v;
    logic                     w_n2_nz;
    logic [2:0][UW-1:0]       w_n2_r;
    logic [TAG_BITS2-1:0]     w_n2_tag;
    t_tag2                    w_t2;

    logic                     r_p1_v;
    logic [5:0][UPR_BITS-1:0] r_p1_up;
    logic [2:0][PRD_BITS-1:0] r_p1_rp;
    logic [2:0][PRD_BITS-1:0] r_p1_fp;
    logic [2:0][UW-1:0]       r_p1_r;
    logic [2:0][UW-1:0]       r_p1_f;
    logic [2:0][31:0]         r_p1_eye;
    logic                     r_p1_dg;

    logic                     r_p2_v;
    logic [2:0][UR_BITS-1:0]  r_p2_ur;
    logic signed [DOT_BITS-1:0] r_p2_dr;
    logic signed [DOT_BITS-1:0] r_p2_df;
    logic [2:0][UW-1:0]       r_p2_r;
    logic [2:0][UW-1:0]       r_p2_f;
    logic [2:0][31:0]         r_p2_eye;
    logic                     r_p2_dg;

    logic                     r_p3_v;
    logic [2:0][UW-1:0]       r_p3_u;
    logic signed [WIDE-1:0]   r_p3_dr;
    logic signed [WIDE-1:0]   r_p3_df;
    logic [2:0][UW-1:0]       r_p3_r;
    logic [2:0][UW-1:0]       r_p3_f;
    logic [2:0][31:0]         r_p3_eye;
    logic                     r_p3_dg;

    logic                     r_p4_v;
    logic [2:0][PRD_BITS-1:0] r_p4_up;
    logic [2:0][UW-1:0]       r_p4_u;
    logic signed [WIDE-1:0]   r_p4_dr;
    logic signed [WIDE-1:0]   r_p4_df;
    logic [2:0][UW-1:0]       r_p4_r;
    logic [2:0][UW-1:0]       r_p4_f;
    logic                     r_p4_dg;

    logic                     r_p5_v;
    logic signed [DOT_BITS-1:0] r_p5_du;
    logic [2:0][UW-1:0]       r_p5_u;
    logic signed [WIDE-1:0]   r_p5_dr;
    logic signed [WIDE-1:0]   r_p5_df;
    logic [2:0][UW-1:0]       r_p5_r;
    logic [2:0][UW-1:0]       r_p5_f;
    logic                     r_p5_dg;

    logic                     r_fin_v;
    logic [3:0][3:0][31:0]    r_fin_ent;
    logic                     r_fin_dg;

    logic                     r_ser_v;
    logic [1:0]               r_ser_col;
    logic [3:0][3:0][31:0]    r_ser_ent;
    logic                     r_ser_dg;

    logic signed [PRD_BITS-1:0] n_x1_p  [6];
    logic signed [RR_BITS-1:0]  n_x2_rr [3];
    logic signed [UPR_BITS-1:0] n_p1_up [6];
    logic signed [PRD_BITS-1:0] n_p1_rp [3];
    logic signed [PRD_BITS-1:0] n_p1_fp [3];
    logic signed [UR_BITS-1:0]  n_p2_ur [3];
    logic signed [DOT_BITS-1:0] n_p2_dr;
    logic signed [DOT_BITS-1:0] n_p2_df;
    logic signed [WIDE-1:0]     n_p3_t  [3];
    logic signed [PRD_BITS-1:0] n_p4_up [3];
    logic signed [DOT_BITS-1:0] n_p5_du;
    logic [3:0][3:0][31:0]      n_fin_ent;

    assign ser_free   = !r_ser_v || (r_ser_col == COL_LAST && !i_out_stall);
    assign en         = !r_fin_v || ser_free;
    assign o_in_stall = !en;

    // forward difference and first normalizer
    always_comb begin
        w_fd[2] = {r_s0_d.target_x[31], r_s0_d.target_x} - {r_s0_d.eye_x[31], r_s0_d.eye_x};
        w_fd[1] = {r_s0_d.target_y[31], r_s0_d.target_y} - {r_s0_d.eye_y[31], r_s0_d.eye_y};
        w_fd[0] = {r_s0_d.target_z[31], r_s0_d.target_z} - {r_s0_d.eye_z[31], r_s0_d.eye_z};
        w_tag1.eye = {r_s0_d.eye_x, r_s0_d.eye_y, r_s0_d.eye_z};
        w_tag1.up  = {r_s0_d.up_x, r_s0_d.up_y, r_s0_d.up_z};
    end

    lvm_norm #(
        .VEC_BITS  (DIF_BITS),
        .FRAC_BITS (FRAC_BITS),
        .TAG_BITS  (TAG_BITS1)
    ) u_norm_f (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s0_v),
        .i_vec     (w_fd),
        .i_tag     (w_tag1),
        .o_valid   (w_n1_v),
        .o_nonzero (w_n1_nz),
        .o_unit    (w_n1_f),
        .o_tag     (w_n1_tag)
    );

    assign w_t1 = t_tag1'(w_n1_tag);

    // packed element 2 is x, 0 is z
    always_comb begin
        n_x1_p[0] = $signed(w_n1_f[1]) * $signed(w_t1.up[0]);  // fy*uz
        n_x1_p[1] = $signed(w_n1_f[0]) * $signed(w_t1.up[1]);  // fz*uy
        n_x1_p[2] = $signed(w_n1_f[0]) * $signed(w_t1.up[2]);  // fz*ux
        n_x1_p[3] = $signed(w_n1_f[2]) * $signed(w_t1.up[0]);  // fx*uz
        n_x1_p[4] = $signed(w_n1_f[2]) * $signed(w_t1.up[1]);  // fx*uy
        n_x1_p[5] = $signed(w_n1_f[1]) * $signed(w_t1.up[2]);  // fy*ux
        n_x2_rr[2] = RR_BITS'($signed(r_x1_p[0])) - RR_BITS'($signed(r_x1_p[1]));
        n_x2_rr[1] = RR_BITS'($signed(r_x1_p[2])) - RR_BITS'($signed(r_x1_p[3]));
        n_x2_rr[0] = RR_BITS'($signed(r_x1_p[4])) - RR_BITS'($signed(r_x1_p[5]));
    end

    lvm_norm #(
        .VEC_BITS  (RR_BITS),
        .FRAC_BITS (FRAC_BITS),
        .TAG_BITS  (TAG_BITS2)
    ) u_norm_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_x2_v),
        .i_vec     (r_x2_rr),
        .i_tag     (r_x2_tag),
        .o_valid   (w_n2_v),
        .o_nonzero (w_n2_nz),
        .o_unit    (w_n2_r),
        .o_tag     (w_n2_tag)
    );

    assign w_t2 = t_tag2'(w_n2_tag);

    always_comb begin
        n_p1_up[0] = $signed(w_n2_r[1]) * $signed(w_t2.f[0]);
        n_p1_up[1] = $signed(w_n2_r[0]) * $signed(w_t2.f[1]);
        n_p1_up[2] = $signed(w_n2_r[0]) * $signed(w_t2.f[2]);
        n_p1_up[3] = $signed(w_n2_r[2]) * $signed(w_t2.f[0]);
        n_p1_up[4] = $signed(w_n2_r[2]) * $signed(w_t2.f[1]);
        n_p1_up[5] = $signed(w_n2_r[1]) * $signed(w_t2.f[2]);
        for (int k = 0; k < 3; k++) begin
            n_p1_rp[k] = $signed(w_n2_r[k]) * $signed(w_t2.eye[k]);
            n_p1_fp[k] = $signed(w_t2.f[k]) * $signed(w_t2.eye[k]);
        end
        n_p2_ur[2] = UR_BITS'($signed(r_p1_up[0])) - UR_BITS'($signed(r_p1_up[1]));
        n_p2_ur[1] = UR_BITS'($signed(r_p1_up[2])) - UR_BITS'($signed(r_p1_up[3]));
        n_p2_ur[0] = UR_BITS'($signed(r_p1_up[4])) - UR_BITS'($signed(r_p1_up[5]));
        n_p2_dr = DOT_BITS'($signed(r_p1_rp[0])) + DOT_BITS'($signed(r_p1_rp[1]))
                + DOT_BITS'($signed(r_p1_rp[2]));
        n_p2_df = DOT_BITS'($signed(r_p1_fp[0])) + DOT_BITS'($signed(r_p1_fp[1]))
                + DOT_BITS'($signed(r_p1_fp[2]));
        for (int k = 0; k < 3; k++) begin
            n_p3_t[k] = rnd(WIDE'($signed(r_p2_ur[k])));
            if (n_p3_t[k] > ONE) n_p3_t[k] = ONE;
            if (n_p3_t[k] < -ONE) n_p3_t[k] = -ONE;
        end
        for (int k = 0; k < 3; k++) begin
            n_p4_up[k] = $signed(r_p3_u[k]) * $signed(r_p3_eye[k]);
        end
        n_p5_du = DOT_BITS'($signed(r_p4_up[0])) + DOT_BITS'($signed(r_p4_up[1]))
                + DOT_BITS'($signed(r_p4_up[2]));
    end

    // column c of rows: r, u, -f, 0; translation column last
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_fin_ent[c][0] = sat(WIDE'($signed(r_p5_r[2-c])));
            n_fin_ent[c][1] = sat(WIDE'($signed(r_p5_u[2-c])));
            n_fin_ent[c][2] = sat(-WIDE'($signed(r_p5_f[2-c])));
            n_fin_ent[c][3] = '0;
        end
        n_fin_ent[3][0] = sat(-r_p5_dr);
        n_fin_ent[3][1] = sat(-rnd(WIDE'(r_p5_du)));
        n_fin_ent[3][2] = sat(r_p5_df);
        n_fin_ent[3][3] = sat(ONE);
        if (r_p5_dg) n_fin_ent = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_x1_v  <= 1'b0;
            r_x2_v  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_fin_v <= 1'b0;
        end else if (en) begin
            r_s0_v  <= i_in_valid;
            r_x1_v  <= w_n1_v;
            r_x2_v  <= r_x1_v;
            r_p1_v  <= w_n2_v;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_p5_v  <= r_p4_v;
            r_fin_v <= r_p5_v;
        end
        if (en) begin
            r_s0_d <= i_in_data;
            for (int k = 0; k < 6; k++) r_x1_p[k] <= n_x1_p[k];
            r_x1_eye <= w_t1.eye;
            r_x1_f   <= w_n1_f;
            r_x1_nz  <= w_n1_nz;
            for (int k = 0; k < 3; k++) r_x2_rr[k] <= n_x2_rr[k];
            r_x2_tag.eye <= r_x1_eye;
            r_x2_tag.f   <= r_x1_f;
            r_x2_tag.nz  <= r_x1_nz;
            for (int k = 0; k < 6; k++) r_p1_up[k] <= n_p1_up[k];
            for (int k = 0; k < 3; k++) begin
                r_p1_rp[k] <= n_p1_rp[k];
                r_p1_fp[k] <= n_p1_fp[k];
            end
            r_p1_r   <= w_n2_r;
            r_p1_f   <= w_t2.f;
            r_p1_eye <= w_t2.eye;
            r_p1_dg  <= !w_t2.nz || !w_n2_nz;
            for (int k = 0; k < 3; k++) r_p2_ur[k] <= n_p2_ur[k];
            r_p2_dr  <= n_p2_dr;
            r_p2_df  <= n_p2_df;
            r_p2_r   <= r_p1_r;
            r_p2_f   <= r_p1_f;
            r_p2_eye <= r_p1_eye;
            r_p2_dg  <= r_p1_dg;
            for (int k = 0; k < 3; k++) r_p3_u[k] <= UW'(n_p3_t[k]);
            r_p3_dr  <= rnd(WIDE'(r_p2_dr));
            r_p3_df  <= rnd(WIDE'(r_p2_df));
            r_p3_r   <= r_p2_r;
            r_p3_f   <= r_p2_f;
            r_p3_eye <= r_p2_eye;
            r_p3_dg  <= r_p2_dg;
            for (int k = 0; k < 3; k++) r_p4_up[k] <= n_p4_up[k];
            r_p4_u   <= r_p3_u;
            r_p4_dr  <= r_p3_dr;
            r_p4_df  <= r_p3_df;
            r_p4_r   <= r_p3_r;
            r_p4_f   <= r_p3_f;
            r_p4_dg  <= r_p3_dg;
            r_p5_du  <= n_p5_du;
            r_p5_u   <= r_p4_u;
            r_p5_dr  <= r_p4_dr;
            r_p5_df  <= r_p4_df;
            r_p5_r   <= r_p4_r;
            r_p5_f   <= r_p4_f;
            r_p5_dg  <= r_p4_dg;
            r_fin_ent <= n_fin_ent;
            r_fin_dg  <= r_p5_dg;
        end
    end

    // column serializer: four transfers per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v   <= 1'b0;
            r_ser_col <= '0;
        end else if (ser_free) begin
            r_ser_v   <= r_fin_v;
            r_ser_col <= '0;
        end else if (!i_out_stall) begin
            r_ser_col <= r_ser_col + 2'd1;
        end
        if (ser_free && r_fin_v) begin
            r_ser_ent <= r_fin_ent;
            r_ser_dg  <= r_fin_dg;
        end
    end

    always_comb begin
        o_out_data.column_index = r_ser_col;
        o_out_data.entry_0      = r_ser_ent[r_ser_col][0];
        o_out_data.entry_1      = r_ser_ent[r_ser_col][1];
        o_out_data.entry_2      = r_ser_ent[r_ser_col][2];
        o_out_data.entry_3      = r_ser_ent[r_ser_col][3];
        o_out_data.degenerate   = r_ser_dg;
        o_out_data.last_column  = (r_ser_col == COL_LAST);
    end

    assign o_out_valid = r_ser_v;

    `ASSERT_NXT(a_col_step, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_data.last_column, o_out_valid && (o_out_data.column_index == $past(o_out_data.column_index) + 2'd1))
    `ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, o_out_data.entry_0 == 32'sd0 && o_out_data.entry_1 == 32'sd0 && o_out_data.entry_2 == 32'sd0 && o_out_data.entry_3 == 32'sd0)
    `ASSERT_IMP(a_stall_src, i_clk, i_rst_n, o_in_stall, r_fin_v && r_ser_v)
    `ASSERT_NXT(a_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_data.last_column && !r_fin_v, !o_out_valid)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for lookat_view_matrix. Drives eye/target/up triples through
// the valid/stall input channel with bursty gaps and a randomly stalling
// receiver. It predicts the four view-matrix columns of every input transfer
// and checks each output transfer in order against them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lvm_pkg::*;

    localparam int FB         = LVM_FRAC_BITS;
    localparam int N_RANDOM   = 220;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 500;
    localparam int DRAIN_WAIT = 2 * LVM_FRAC_BITS + 120;

    class lvm_scoreboard;
        t_lvm_out columns_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function longint round_q(longint x);
            longint unsigned m;
            m = mag(x);
            m = (m + (64'd1 << (FB - 1))) >> FB;
            return x < 0 ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function bit normalize(input longint v[3], output longint o[3]);
            longint unsigned m[3];
            longint unsigned big;
            longint unsigned len;
            longint unsigned q;
            for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
            big = m[0];
            if (m[1] > big) big = m[1];
            if (m[2] > big) big = m[2];
            for (int i = 0; i < 3; i++) o[i] = 0;
            if (big == 0) return 0;
            while (big >= (64'd1 << 31)) begin
                big = big >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (big < (64'd1 << 30)) begin
                big = big << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << FB) + (len >> 1)) / len;
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function void cross3(input longint a[3], input longint b[3], output longint o[3]);
            o[0] = a[1] * b[2] - a[2] * b[1];
            o[1] = a[2] * b[0] - a[0] * b[2];
            o[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        function longint dot(input longint a[3], input longint b[3]);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_input(t_lvm_in d);
            longint eye[3], tgt[3], up[3], fd[3], f[3], rr[3], r[3], u[3];
            longint ent[4][4];
            longint one;
            bit degen;
            t_lvm_out col;
            one = 64'sd1 <<< FB;
            eye = '{d.eye_x, d.eye_y, d.eye_z};
            tgt = '{d.target_x, d.target_y, d.target_z};
            up  = '{d.up_x, d.up_y, d.up_z};
            for (int i = 0; i < 3; i++) fd[i] = tgt[i] - eye[i];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) ent[c][i] = 0;
            degen = 0;
            if (!normalize(fd, f)) begin
                degen = 1;
            end else begin
                cross3(f, up, rr);
                if (!normalize(rr, r)) degen = 1;
            end
            if (!degen) begin
                cross3(r, f, u);
                for (int i = 0; i < 3; i++) begin
                    u[i] = round_q(u[i]);
                    if (u[i] > one) u[i] = one;
                    if (u[i] < -one) u[i] = -one;
                end
                for (int c = 0; c < 3; c++) begin
                    ent[c][0] = r[c];
                    ent[c][1] = u[c];
                    ent[c][2] = -f[c];
                end
                ent[3][0] = -round_q(dot(r, eye));
                ent[3][1] = -round_q(dot(u, eye));
                ent[3][2] = round_q(dot(f, eye));
                ent[3][3] = one;
            end
            for (int c = 0; c < 4; c++) begin
                col.column_index = c[1:0];
                col.entry_0      = sat32(ent[c][0]);
                col.entry_1      = sat32(ent[c][1]);
                col.entry_2      = sat32(ent[c][2]);
                col.entry_3      = sat32(ent[c][3]);
                col.degenerate   = degen;
                col.last_column  = (c[1:0] == COL_LAST);
                columns_q.push_back(col);
            end
        endfunction

        function void check_column(t_lvm_out got);
            t_lvm_out exp_col;
            if (columns_q.size() == 0) begin
                $display("%0t unexpected column transfer: got %p", $time, got);
                errors++;
                return;
            end
            exp_col = columns_q.pop_front();
            if (got !== exp_col) begin
                $display("%0t column mismatch: expected %p actual %p", $time, exp_col, got);
                errors++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_lvm_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_lvm_out o_out_data;

    lvm_scoreboard sb;
    int  idle_cycles;
    int  n_sent;
    int  burst_left;
    bit  hold_off;

    lookat_view_matrix u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_column(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[lookat_view_matrix] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver: stall pattern changes mode every so often
    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_off)       i_out_stall <= 1'b1;
            else if (mode == 0) i_out_stall <= 1'b0;
            else if (mode == 1) i_out_stall <= ($urandom_range(0, 9) < 3);
            else if (mode == 2) i_out_stall <= ($urandom_range(0, 9) < 7);
            else                i_out_stall <= ($urandom_range(0, 9) < 5);
        end
    end

    // long receiver hold-off while input keeps coming
    initial begin
        hold_off = 1'b0;
        wait (n_sent >= 60);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic t_lvm_in make_item(int ex, int ey, int ez, int tx, int ty, int tz,
                                          int ux, int uy, int uz);
        t_lvm_in d;
        d.eye_x = ex; d.eye_y = ey; d.eye_z = ez;
        d.target_x = tx; d.target_y = ty; d.target_z = tz;
        d.up_x = ux; d.up_y = uy; d.up_z = uz;
        return d;
    endfunction

    function automatic int moderate();
        return int'($urandom_range(0, 200 << FB)) - (100 << FB);
    endfunction

    function automatic t_lvm_in random_item();
        t_lvm_in d;
        int kind;
        int fx, fy, fz, k;
        kind = $urandom_range(0, 99);
        d = make_item(moderate(), moderate(), moderate(), moderate(), moderate(),
                      moderate(), moderate(), moderate(), moderate());
        if (kind < 15) begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end else if (kind < 25) begin
            d.target_x = d.eye_x; d.target_y = d.eye_y; d.target_z = d.eye_z;
        end else if (kind < 35) begin
            fx = int'($urandom_range(0, 2000)) - 1000;
            fy = int'($urandom_range(0, 2000)) - 1000;
            fz = int'($urandom_range(0, 2000)) - 1000;
            k  = int'($urandom_range(0, 6)) - 3;
            d.target_x = d.eye_x + fx; d.target_y = d.eye_y + fy; d.target_z = d.eye_z + fz;
            d.up_x = fx * k; d.up_y = fy * k; d.up_z = fz * k;
        end else if (kind < 40) begin
            d.up_x = 0; d.up_y = 0; d.up_z = 0;
        end else if (kind < 48) begin
            d.target_x = d.eye_x + int'($urandom_range(0, 4)) - 2;
            d.target_y = d.eye_y + int'($urandom_range(0, 4)) - 2;
            d.target_z = d.eye_z + int'($urandom_range(0, 4)) - 2;
        end
        return d;
    endfunction

    task automatic send_item(t_lvm_in d);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        localparam int MX = 32'h7fffffff;
        localparam int MN = 32'h80000000;
        localparam int ONE = 1 << FB;
        sb = new();
        idle_cycles = 0;
        n_sent = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(make_item(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
        send_item(make_item(3 * ONE, -ONE, 7, 3 * ONE, -ONE, 7, 0, ONE, 0));
        send_item(make_item(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0));
        send_item(make_item(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(MX, MX, MX, MN, MN, MN, MN, MX, 0));
        send_item(make_item(MN, MN, MN, MX, MX, MX, MX, MX, MN));
        send_item(make_item(MN, MX, MN, MN, MX, MX, MN, MN, MN));
        send_item(make_item(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_item(make_item(MX, MX, MX, MX - ONE, MX, MX, 0, ONE, 0));
        send_item(make_item(MN, MN, MN, MN, MN + ONE, MN, ONE, 0, 0));
        send_item(make_item(MX, MN, MX, MX, MN, MX - 1, MX, 0, MN));
        send_item(make_item(ONE, ONE, ONE, -ONE, -ONE, -ONE, MN, MX, MN));
        send_item(make_item(-1, -1, -1, 0, 0, 0, -1, 1, -1));
        send_item(make_item(10 * ONE, 0, 0, 0, 0, 0, 0, -ONE, 0));
        for (int n = 0; n < N_RANDOM; n++) send_item(random_item());
        i_in_valid <= 1'b0;

        while (sb.columns_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[lookat_view_matrix] OK");
        end else begin
            $display("[lookat_view_matrix] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/lvm_pkg.sv
rtl/lvm_norm.sv
rtl/lookat_view_matrix.sv
tb/tb_top.sv
